/* hw/rtl/tte_pkg.sv */
// shared types, constants and score helpers for the transposition table engine
`default_nettype none

package tte_pkg;

    localparam int ENTRIES_DEFAULT = 1024;
    localparam int MATE_VALUE      = 30000;
    localparam int MAX_PLY         = 64;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int PLY_W   = 10;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 32;

    // stream payload widths
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    localparam logic KIND_PROBE = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic signed [DEPTH_W-1:0] depth_t;
    typedef logic signed [SCORE_W+1:0] wide_score_t;

    typedef enum logic [BOUND_W-1:0] {
        BOUND_EXACT = 2'd0,
        BOUND_LOWER = 2'd1,
        BOUND_UPPER = 2'd2
    } bound_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        score_t             score;
        depth_t             depth;
        logic [BOUND_W-1:0] bound;
        logic [MOVE_W-1:0]  move;
    } tte_entry_t;

    localparam int ENTRY_W = $bits(tte_entry_t);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } tte_state_t;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic rd;
        logic finish;
    } tte_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } tte_stat_t;

    localparam wide_score_t MATE_LIMIT = 18'(MATE_VALUE - MAX_PLY);
    localparam wide_score_t SAT_HI     = 18'sd32767;
    localparam wide_score_t SAT_LO     = -18'sd32767;
    localparam score_t      SCORE_MIN  = 16'sh8000;

    // clamp an input score into the symmetric range
    function automatic score_t sat_in(input score_t v);
        return (v == SCORE_MIN) ? score_t'(-16'sd32767) : v;
    endfunction

    function automatic score_t sat16(input wide_score_t v);
        if (v > SAT_HI)
            return score_t'(SAT_HI[SCORE_W-1:0]);
        if (v < SAT_LO)
            return score_t'(SAT_LO[SCORE_W-1:0]);
        return v[SCORE_W-1:0];
    endfunction

    function automatic wide_score_t widen(input score_t s);
        return {{2{s[SCORE_W-1]}}, s};
    endfunction

    function automatic wide_score_t widen_ply(input logic [PLY_W-1:0] p);
        return {{(SCORE_W+2-PLY_W){1'b0}}, p};
    endfunction

    // mate scores stored independent of ply
    function automatic score_t to_table(input score_t s, input logic [PLY_W-1:0] p);
        wide_score_t ws;
        ws = widen(s);
        if (ws > MATE_LIMIT)
            return sat16(ws + widen_ply(p));
        if (ws < -MATE_LIMIT)
            return sat16(ws - widen_ply(p));
        return s;
    endfunction

    function automatic score_t from_table(input score_t s, input logic [PLY_W-1:0] p);
        wide_score_t ws;
        ws = widen(s);
        if (ws > MATE_LIMIT)
            return sat16(ws - widen_ply(p));
        if (ws < -MATE_LIMIT)
            return sat16(ws + widen_ply(p));
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tte_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tte_ctrl.sv */
// sequencing state machine: clearing pass, capture, slot read, execute
`default_nettype none

module tte_ctrl
    import tte_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire tte_stat_t stat,
    output tte_cmd_t       cmd
);

    tte_state_t state_reg;
    tte_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/tte_datapath.sv */
// item registers, slot memory, replacement and cutoff logic, output register
`default_nettype none

module tte_datapath
    import tte_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tte_cmd_t              cmd,
    output tte_stat_t                  stat,
    input  wire logic [IN_DATA_W-1:0]  in_data,  // key, search_depth, lower_bound,
                                                 // upper_bound, ply, new_score,
                                                 // bound_kind, move_in, pad
    input  wire logic                  in_user,  // kind
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data, // score_out, move_out
    output logic [OUT_USER_W-1:0]      out_user  // cutoff, key_hit
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ENTRIES - 1);

    logic               kind_reg;
    logic [KEY_W-1:0]   key_reg;
    depth_t             depth_reg;
    score_t             alpha_reg;
    score_t             beta_reg;
    logic [PLY_W-1:0]   ply_reg;
    score_t             score_reg;
    logic [BOUND_W-1:0] bound_reg;
    logic [MOVE_W-1:0]  move_reg;
    score_t             tab_score_reg;

    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [IDX_W-1:0]   clr_cnt_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               cutoff_reg;
    logic               hit_reg;
    score_t             score_out_reg;
    logic [MOVE_W-1:0]  move_out_reg;

    logic               cutoff_next;
    logic               hit_next;
    score_t             score_out_next;
    logic [MOVE_W-1:0]  move_out_next;

    logic [IDX_W-1:0]   slot_idx;
    tte_entry_t         slot_rd;
    logic [ENTRY_W-1:0] slot_rd_bits;
    tte_entry_t         slot_wr;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;

    logic               key_match;
    logic               replace;
    logic               deep_enough;
    score_t             tab_to_ply;

    assign slot_idx = key_reg[IDX_W-1:0] & IDX_MASK;
    assign slot_rd  = tte_entry_t'(slot_rd_bits);

    // item capture and store score conversion
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= in_user;
            key_reg   <= in_data[63:0];
            depth_reg <= depth_t'(in_data[71:64]);
            alpha_reg <= sat_in(score_t'(in_data[87:72]));
            beta_reg  <= sat_in(score_t'(in_data[103:88]));
            ply_reg   <= in_data[113:104];
            score_reg <= sat_in(score_t'(in_data[129:114]));
            bound_reg <= in_data[131:130];
            move_reg  <= in_data[163:132];
        end
        if (cmd.rd)
        begin
            tab_score_reg <= to_table(score_reg, ply_reg);
        end
    end

    assign clr_cnt_next = cmd.clear_wr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign stat.clear_last = (clr_cnt_reg == IDX_MASK) || (clr_cnt_reg == IDX_W'(ENTRIES - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    // slot decision
    always_comb
    begin
        key_match   = (slot_rd.key == key_reg);
        replace     = (slot_rd.key == '0) || key_match || (depth_reg >= slot_rd.depth);
        deep_enough = (slot_rd.depth >= depth_reg);
        tab_to_ply  = from_table(slot_rd.score, ply_reg);

        cutoff_next    = 1'b0;
        hit_next       = 1'b0;
        score_out_next = '0;
        move_out_next  = '0;
        if (kind_reg == KIND_PROBE && key_match)
        begin
            hit_next      = 1'b1;
            move_out_next = slot_rd.move;
            if (deep_enough)
            begin
                case (slot_rd.bound)
                    BOUND_EXACT:
                    begin
                        cutoff_next    = 1'b1;
                        score_out_next = tab_to_ply;
                    end
                    BOUND_LOWER:
                    begin
                        if (tab_to_ply >= beta_reg)
                        begin
                            cutoff_next    = 1'b1;
                            score_out_next = beta_reg;
                        end
                    end
                    BOUND_UPPER:
                    begin
                        if (tab_to_ply <= alpha_reg)
                        begin
                            cutoff_next    = 1'b1;
                            score_out_next = alpha_reg;
                        end
                    end
                    default:
                    begin
                        cutoff_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        slot_wr.key   = key_reg;
        slot_wr.score = tab_score_reg;
        slot_wr.depth = depth_reg;
        slot_wr.bound = bound_reg;
        slot_wr.move  = move_reg;
        ram_we        = 1'b0;
        ram_waddr     = slot_idx;
        if (cmd.clear_wr)
        begin
            slot_wr   = '0;
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (cmd.finish && kind_reg == KIND_STORE && replace)
        begin
            ram_we = 1'b1;
        end
    end

    tte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ENTRY_W'(slot_wr)),
        .re    (cmd.rd),
        .raddr (slot_idx),
        .rdata (slot_rd_bits)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            cutoff_reg    <= cutoff_next;
            hit_reg       <= hit_next;
            score_out_reg <= score_out_next;
            move_out_reg  <= move_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {move_out_reg, score_out_reg};
    assign out_user  = {hit_reg, cutoff_reg};

endmodule

`default_nettype wire

/* hw/rtl/transposition_table_engine.sv */
// top level of the transposition table engine
//
// A direct-mapped search hash table. Each slave transaction is a probe
// (tuser 0) or a store (tuser 1); every transaction yields exactly one
// master transaction, in order. A store result is all zero; a probe
// returns key_hit with the stored move and, when the stored depth and
// bound allow it, cutoff with a score.
// After rst_n is released the engine runs a clearing pass over the slot
// memory, one slot per cycle, over all ENTRIES slots (1024 by default);
// s_axis_tready stays low until it is done.
// Each transaction then goes through capture, slot read from the
// single memory read port, then compare and slot write-back. The next
// transaction is accepted in the cycle after that, never while one is in
// these steps. m_axis_tvalid rises once the compare result is registered.
// The result sits in an output register; while it waits for
// m_axis_tready, one more transaction is taken and held in its final
// step until the register frees up.
`default_nettype none

module transposition_table_engine
    import tte_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // key, search_depth, lower_bound, upper_bound, ply, new_score,
    // bound_kind, move_in, 4 zero bits
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tuser,  // kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // score_out, move_out
    output logic [OUT_USER_W-1:0]      m_axis_tuser   // cutoff, key_hit
);

    tte_cmd_t  cmd;
    tte_stat_t stat;

    tte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tte_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* hw/rtl/tte_checker.sv */
// port-level assertions for the transposition table engine, bound to the top
`default_nettype none

module tte_checker
    import tte_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic                  s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [OUT_USER_W-1:0] m_axis_tuser
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction accepted too early");

    // a fresh result traces back to an accepted transaction
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
        else $error("result without matching transaction");

    a_cutoff_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("cutoff without key hit");

    a_no_cutoff_score: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == '0)
        else $error("score present without cutoff");

endmodule

bind transposition_table_engine tte_checker u_tte_checker (.*);

`default_nettype wire
